[sv/sialu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sialu_pkg
// Operation and status codes shared by the signed integer ALU.
// ----------------------------------------------------------------------------
package sialu_pkg;

  localparam int OP_W  = 3;
  localparam int ERR_W = 2;

  localparam logic [OP_W-1:0] OP_ADD = 3'd0;
  localparam logic [OP_W-1:0] OP_SUB = 3'd1;
  localparam logic [OP_W-1:0] OP_MUL = 3'd2;
  localparam logic [OP_W-1:0] OP_DIV = 3'd3;
  localparam logic [OP_W-1:0] OP_POW = 3'd4;

  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
  localparam logic [ERR_W-1:0] ERR_DIV_OVF  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NEG_EXP  = 2'd3;

endpackage

[sv/signed_int_alu_with_power_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_alu_with_power_top
// Signed integer ALU: add, subtract, multiply, divide and power, one result
// per request, built around a shared digit multiplier and a radix-2 divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in      | input     | in_valid / in_stall | req_type, operand_a, operand_b
//  out     | output    | out_valid/out_stall | result_value, error_code
//
//  Add, subtract, flagged requests and unused codes go straight to the done
//  state; multiply steps through NDIG multiplier digits of up to 16 bits (2 at
//  32 bits), and divide takes one quotient bit a cycle. Power scans the exponent
//  bit by bit, as one multiplier does both the multiply-in and the square.
//  in_stall is high while a request is worked on; a finished result waits in
//  the output register while the next one is taken. Reset clears the sequencer.
// ----------------------------------------------------------------------------
module signed_int_alu_with_power_top
  import sialu_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [OP_W-1:0]              req_type,
  input  logic signed [DATA_WIDTH-1:0] operand_a,
  input  logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] result_value,
  output logic [ERR_W-1:0]             error_code
);

  localparam int W    = DATA_WIDTH;
  localparam int DW   = (W < 16) ? W : 16;
  localparam int NDIG = (W + DW - 1) / DW;
  localparam int MW   = NDIG * DW;
  localparam int CNTW = $clog2(W + 1);

  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_VAL = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] ALL_ONE = {W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_POW_CHK,
    S_POW_ACC,
    S_POW_SQR,
    S_DONE
  } state_t;

  state_t           state;
  logic [CNTW-1:0]  cnt;
  logic [W-1:0]     mul_p;
  logic [W-1:0]     mcand;
  logic [MW-1:0]    mplier;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic             neg;
  logic [W-1:0]     pow_acc;
  logic [W-1:0]     pow_base;
  logic [W-1:0]     pow_exp;
  logic [W-1:0]     res;
  logic [ERR_W-1:0] err;

  logic [W-1:0]     opa;
  logic [W-1:0]     opb;
  logic [W-1:0]     mag_a;
  logic [W-1:0]     mag_b;
  logic [W+DW-1:0]  prod;
  logic [W-1:0]     mul_sum;
  logic             step_last;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic [W-1:0]     quo_next;
  logic [W-1:0]     rem_next;

  assign opa   = operand_a;
  assign opb   = operand_b;
  assign mag_a = opa[W-1] ? (~opa + 1'b1) : opa;
  assign mag_b = opb[W-1] ? (~opb + 1'b1) : opb;

  // One digit of the multiplier per cycle; the multiplicand moves up a digit.
  assign prod      = mcand * mplier[DW-1:0];
  assign mul_sum   = mul_p + prod[W-1:0];
  assign step_last = (cnt == CNTW'(1));

  // Restoring division step on magnitudes.
  assign rem_sh   = {rem, quo[W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quo_next = {quo[W-2:0], ~diff[W]};
  assign rem_next = diff[W] ? rem_sh[W-1:0] : diff[W-1:0];

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res <= '0;
            err <= ERR_OK;
            state <= S_DONE;
            case (req_type)
              OP_ADD: res <= opa + opb;
              OP_SUB: res <= opa - opb;
              OP_MUL: begin
                mul_p  <= '0;
                mcand  <= opa;
                mplier <= MW'(opb);
                cnt    <= CNTW'(NDIG);
                state  <= S_MUL;
              end
              OP_DIV: begin
                if (opb == '0) begin
                  err <= ERR_DIV_ZERO;
                end else if (opa == MIN_VAL && opb == ALL_ONE) begin
                  err <= ERR_DIV_OVF;
                end else begin
                  rem   <= '0;
                  quo   <= mag_a;
                  dvs   <= mag_b;
                  neg   <= opa[W-1] ^ opb[W-1];
                  cnt   <= CNTW'(W);
                  state <= S_DIV;
                end
              end
              OP_POW: begin
                if (opb[W-1]) begin
                  err <= ERR_NEG_EXP;
                end else begin
                  pow_acc  <= ONE_VAL;
                  pow_base <= opa;
                  pow_exp  <= opb;
                  state    <= S_POW_CHK;
                end
              end
              default: ;
            endcase
          end
        end

        S_MUL: begin
          mul_p  <= mul_sum;
          mcand  <= mcand << DW;
          mplier <= mplier >> DW;
          cnt    <= cnt - 1'b1;
          if (step_last) begin
            res   <= mul_sum;
            state <= S_DONE;
          end
        end

        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt - 1'b1;
          if (step_last) begin
            res   <= neg ? (~quo_next + 1'b1) : quo_next;
            state <= S_DONE;
          end
        end

        // Scan the exponent from its low end: multiply in the base for a set
        // bit, otherwise square the base and shift the exponent down.
        S_POW_CHK: begin
          mul_p <= '0;
          cnt   <= CNTW'(NDIG);
          if (pow_exp == '0) begin
            res   <= pow_acc;
            state <= S_DONE;
          end else if (pow_exp[0]) begin
            mcand  <= pow_acc;
            mplier <= MW'(pow_base);
            state  <= S_POW_ACC;
          end else begin
            mcand  <= pow_base;
            mplier <= MW'(pow_base);
            state  <= S_POW_SQR;
          end
        end

        S_POW_ACC: begin
          mul_p  <= mul_sum;
          mcand  <= mcand << DW;
          mplier <= mplier >> DW;
          cnt    <= cnt - 1'b1;
          if (step_last) begin
            pow_acc    <= mul_sum;
            pow_exp[0] <= 1'b0;
            state      <= S_POW_CHK;
          end
        end

        S_POW_SQR: begin
          mul_p  <= mul_sum;
          mcand  <= mcand << DW;
          mplier <= mplier >> DW;
          cnt    <= cnt - 1'b1;
          if (step_last) begin
            pow_base <= mul_sum;
            pow_exp  <= pow_exp >> 1;
            state    <= S_POW_CHK;
          end
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            result_value <= res;
            error_code   <= err;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
